### rtl/core/utfs_pkg.sv
// Shared types and constants for the UART transmit frame serializer.
`timescale 1ns / 1ps
`default_nettype none
package utfs_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_BITS   = 2'd2;

  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_EVEN = 2'd1;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_PARITY = 2'd2;
  localparam logic [1:0] KIND_STOP   = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  last_idx;
    logic              par_en;
    logic              par_bit;
    logic              two_stop;
  } desc_t;

  typedef enum logic [1:0] {
    ST_START,
    ST_DATA,
    ST_PARITY,
    ST_STOP
  } ser_state_t;

endpackage
`default_nettype wire

### rtl/core/utfs_front.sv
// Front end: configuration registers and frame descriptor classification.
`timescale 1ns / 1ps
`default_nettype none
module utfs_front
  import utfs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [DATA_W-1:0]    data_byte,
  output desc_t                     desc
);

  logic [CFG_W-1:0] data_bits_r;
  logic [1:0]       parity_mode_r;
  logic [1:0]       stop_bits_r;
  logic [IDX_W-1:0] last_idx;
  logic [DATA_W-1:0] masked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r   <= 4'd8;
      parity_mode_r <= PAR_NONE;
      stop_bits_r   <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DATA_BITS:   data_bits_r   <= cfg_wdata;
        CFG_PARITY_MODE: parity_mode_r <= cfg_wdata[1:0];
        CFG_STOP_BITS:   stop_bits_r   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (data_bits_r < 4'd5) begin
      last_idx = 3'd4;
    end else if (data_bits_r > 4'd8) begin
      last_idx = 3'd7;
    end else begin
      last_idx = IDX_W'(data_bits_r - 4'd1);
    end
    masked        = data_byte & (8'hFF >> (3'd7 - last_idx));
    desc.data     = data_byte;
    desc.last_idx = last_idx;
    desc.par_en   = (parity_mode_r != PAR_NONE);
    desc.par_bit  = (^masked) ^ (parity_mode_r != PAR_EVEN);
    desc.two_stop = stop_bits_r[1];
  end

endmodule
`default_nettype wire

### rtl/core/utfs_queue.sv
// Two-entry descriptor queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module utfs_queue
  import utfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output desc_t      head_desc
);

  desc_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_desc  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/utfs_back.sv
// Back end: bit sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
module utfs_back
  import utfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  wire desc_t head_desc,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic       out_line_level,
  output logic [1:0] out_bit_kind,
  output logic       out_frame_end
);

  ser_state_t       state_r, state_nxt;
  desc_t            cur_r, cur_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic             level_r, level_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic             end_r, end_nxt;
  logic             can_load;

  assign can_load       = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_line_level = level_r;
  assign out_bit_kind   = kind_r;
  assign out_frame_end  = end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    level_r <= level_nxt;
    kind_r  <= kind_nxt;
    end_r   <= end_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    level_nxt = level_r;
    kind_nxt  = kind_r;
    end_nxt   = end_r;
    pop       = 1'b0;
    if (can_load) begin
      unique case (state_r)
        ST_START: begin
          if (head_valid) begin
            pop       = 1'b1;
            cur_nxt   = head_desc;
            valid_nxt = 1'b1;
            level_nxt = 1'b0;
            kind_nxt  = KIND_START;
            end_nxt   = 1'b0;
            idx_nxt   = '0;
            state_nxt = ST_DATA;
          end
        end
        ST_DATA: begin
          valid_nxt = 1'b1;
          level_nxt = cur_r.data[idx_r];
          kind_nxt  = KIND_DATA;
          end_nxt   = 1'b0;
          if (idx_r == cur_r.last_idx) begin
            idx_nxt   = '0;
            state_nxt = cur_r.par_en ? ST_PARITY : ST_STOP;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        ST_PARITY: begin
          valid_nxt = 1'b1;
          level_nxt = cur_r.par_bit;
          kind_nxt  = KIND_PARITY;
          end_nxt   = 1'b0;
          state_nxt = ST_STOP;
        end
        ST_STOP: begin
          valid_nxt = 1'b1;
          level_nxt = 1'b1;
          kind_nxt  = KIND_STOP;
          if (cur_r.two_stop && (idx_r == 3'd0)) begin
            end_nxt = 1'b0;
            idx_nxt = 3'd1;
          end else begin
            end_nxt   = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_START;
          end
        end
        default: state_nxt = ST_START;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/uart_tx_frame_serializer.sv
// Top level of the UART transmit frame serializer.
//
// Input channel: in_valid / in_stall carry one byte per transaction on
// in_data_byte. Each byte becomes one serial frame on the output channel:
// out_valid / out_stall carry one bit period per transaction, with
// out_line_level, out_bit_kind (start, data, parity, stop) and out_frame_end
// set on the last stop bit.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 data
// bits, 1 parity mode, 2 stop bits); write only while the block is idle.
// The byte is written into the descriptor queue; its start bit is then loaded
// into the back-end output register when the output side is free.
// Throughput: a frame is a start bit, 5..8 data bits, optional parity and
// 1 or 2 stops; the back-end bit sequencer emits one bit per cycle while
// out_stall is low, and frames follow with no gap when a byte is queued.
// A two-entry descriptor queue lets bytes be accepted while a frame is
// still being sent; in_stall is high while the queue is full.
// Reset: rst_n clears the queue and sequencer and restores 8 data bits,
// no parity and one stop bit. When out_stall is high the current bit holds.
`timescale 1ns / 1ps
`default_nettype none
module uart_tx_frame_serializer
  import utfs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [DATA_W-1:0]    in_data_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_line_level,
  output logic [1:0]                out_bit_kind,
  output logic                      out_frame_end
);

  desc_t front_desc;
  desc_t head_desc;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  head_valid;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  utfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .data_byte (in_data_byte),
    .desc      (front_desc)
  );

  utfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_desc  (front_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  utfs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_desc      (head_desc),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_line_level (out_line_level),
    .out_bit_kind   (out_bit_kind),
    .out_frame_end  (out_frame_end)
  );

endmodule
`default_nettype wire
